>>> rtl/lfd_pkg.sv
// lfd_pkg: shared types and constants of the light frame deframer
// used by lfd_parse, lfd_out_fifo and light_frame_deframer; no dependencies
package lfd_pkg;

  // width of the decoded payload length, 8 to 24
  localparam int unsigned LEN_BITS = 24;

  // framing bytes and length codes
  localparam logic [7:0] HEAD_BYTE    = 8'hFF;
  localparam logic [7:0] END_BYTE     = 8'h00;
  localparam logic [7:0] LCODE_MAX    = 8'd250;
  localparam logic [7:0] LCODE_EMPTY  = 8'd251;
  localparam logic [7:0] LCODE_EXT2   = 8'd252;
  localparam logic [7:0] LCODE_EXT3   = 8'd253;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_END   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_CHECK     = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_item_t;

  // one result: a payload byte or a frame status
  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic        sum_match;
    logic        xor_match;
    logic [23:0] payload_length;
    logic [7:0]  serial_number;
  } out_item_t;

  // result handed from the parser to the output queue
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

>>> rtl/lfd_parse.sv
// lfd_parse: per-byte frame state machine, checksum and length decode
// depends on lfd_pkg; each accepted byte updates the registered state
module lfd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  lfd_pkg::in_item_t in_item,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  output lfd_pkg::res_t     res
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_VERSION = 4'd1;
  localparam logic [3:0] PH_SUM     = 4'd2;
  localparam logic [3:0] PH_XOR     = 4'd3;
  localparam logic [3:0] PH_LCODE   = 4'd4;
  localparam logic [3:0] PH_LEXT    = 4'd5;
  localparam logic [3:0] PH_SERIAL  = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_END     = 4'd8;

  localparam int unsigned LB = lfd_pkg::LEN_BITS;

  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    form_r, form_nxt;
  logic [1:0]    left_r, left_nxt;
  logic [LB-1:0] len_r, len_nxt;
  logic [LB-1:0] remain_r, remain_nxt;
  logic [7:0]    run_sum_r, run_sum_nxt;
  logic [7:0]    run_xor_r, run_xor_nxt;
  logic [7:0]    hdr_sum_r, hdr_sum_nxt;
  logic [7:0]    hdr_xor_r, hdr_xor_nxt;
  logic [7:0]    serial_r, serial_nxt;
  logic          enforce_r;

  logic [7:0]    b;
  logic [1:0]    total;
  logic [1:0]    left_eff;
  logic [1:0]    idx;
  logic [23:0]   ext_shift;
  logic          sm;
  logic          xm;

  assign b = in_item.rx_byte;

  // extension length byte placement, little endian
  always_comb begin
    total    = (form_r == 2'd2) ? 2'd2 : 2'd3;
    left_eff = (left_r == 2'd0 || left_r > total) ? total : left_r;
    idx      = total - left_eff;
    case (idx)
      2'd0:    ext_shift = {16'h0000, b};
      2'd1:    ext_shift = {8'h00, b, 8'h00};
      default: ext_shift = {b, 16'h0000};
    endcase
  end

  assign sm = (run_sum_r == hdr_sum_r);
  assign xm = (run_xor_r == hdr_xor_r);

  // next state and result for one byte
  always_comb begin
    phase_nxt   = phase_r;
    form_nxt    = form_r;
    left_nxt    = left_r;
    len_nxt     = len_r;
    remain_nxt  = remain_r;
    run_sum_nxt = run_sum_r;
    run_xor_nxt = run_xor_r;
    hdr_sum_nxt = hdr_sum_r;
    hdr_xor_nxt = hdr_xor_r;
    serial_nxt  = serial_r;
    res         = '0;
    if (acc) begin
      // body bytes feed the running sum and xor
      if (phase_r == PH_LCODE || phase_r == PH_LEXT || phase_r == PH_SERIAL ||
          phase_r == PH_PAYLOAD) begin
        run_sum_nxt = run_sum_r + b;
        run_xor_nxt = run_xor_r ^ b;
      end
      unique case (phase_r)
        PH_HUNT: begin
          if (b == lfd_pkg::HEAD_BYTE) begin
            form_nxt    = '0;
            left_nxt    = '0;
            len_nxt     = '0;
            remain_nxt  = '0;
            run_sum_nxt = '0;
            run_xor_nxt = '0;
            hdr_sum_nxt = '0;
            hdr_xor_nxt = '0;
            serial_nxt  = '0;
            phase_nxt   = PH_VERSION;
          end
        end
        PH_VERSION: phase_nxt = PH_SUM;
        PH_SUM: begin
          hdr_sum_nxt = b;
          phase_nxt   = PH_XOR;
        end
        PH_XOR: begin
          hdr_xor_nxt = b;
          phase_nxt   = PH_LCODE;
        end
        PH_LCODE: begin
          if (b <= lfd_pkg::LCODE_MAX) begin
            form_nxt  = 2'd0;
            len_nxt   = LB'(b);
            phase_nxt = PH_SERIAL;
          end else if (b == lfd_pkg::LCODE_EMPTY) begin
            form_nxt  = 2'd1;
            len_nxt   = '0;
            phase_nxt = PH_SERIAL;
          end else if (b == lfd_pkg::LCODE_EXT2 || b == lfd_pkg::LCODE_EXT3) begin
            form_nxt  = {1'b1, b[0]};
            left_nxt  = {1'b1, b[0]};
            len_nxt   = '0;
            phase_nxt = PH_LEXT;
          end else begin
            res.valid             = 1'b1;
            res.item.out_kind     = lfd_pkg::KIND_STATUS;
            res.item.frame_status = lfd_pkg::ST_BAD_LEN;
            phase_nxt             = PH_HUNT;
          end
        end
        PH_LEXT: begin
          len_nxt  = len_r | ext_shift[LB-1:0];
          left_nxt = left_eff - 2'd1;
          if (left_eff == 2'd1) begin
            phase_nxt = PH_SERIAL;
          end
        end
        PH_SERIAL: begin
          serial_nxt = b;
          remain_nxt = len_r;
          phase_nxt  = (len_r != '0) ? PH_PAYLOAD : PH_END;
        end
        PH_PAYLOAD: begin
          res.valid             = 1'b1;
          res.item.out_kind     = lfd_pkg::KIND_PAYLOAD;
          res.item.payload_byte = b;
          remain_nxt            = remain_r - LB'(1);
          if (remain_r == LB'(1)) begin
            phase_nxt = PH_END;
          end
        end
        PH_END: begin
          res.valid               = 1'b1;
          res.item.out_kind       = lfd_pkg::KIND_STATUS;
          res.item.sum_match      = sm;
          res.item.xor_match      = xm;
          res.item.payload_length = 24'(len_r);
          res.item.serial_number  = serial_r;
          if (b != lfd_pkg::END_BYTE) begin
            res.item.frame_status = lfd_pkg::ST_BAD_END;
          end else if (enforce_r && !(sm && xm)) begin
            res.item.frame_status = lfd_pkg::ST_CHECK;
          end else begin
            res.item.frame_status = lfd_pkg::ST_OK;
          end
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
      // buffer ended inside a frame: report truncation instead
      if (in_item.chunk_end && phase_nxt != PH_HUNT) begin
        res                     = '0;
        res.valid               = 1'b1;
        res.item.out_kind       = lfd_pkg::KIND_STATUS;
        res.item.frame_status   = lfd_pkg::ST_TRUNCATED;
        res.item.payload_length = 24'(len_nxt);
        res.item.serial_number  = serial_nxt;
        phase_nxt               = PH_HUNT;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      form_r    <= '0;
      left_r    <= '0;
      len_r     <= '0;
      remain_r  <= '0;
      run_sum_r <= '0;
      run_xor_r <= '0;
      hdr_sum_r <= '0;
      hdr_xor_r <= '0;
      serial_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      form_r    <= form_nxt;
      left_r    <= left_nxt;
      len_r     <= len_nxt;
      remain_r  <= remain_nxt;
      run_sum_r <= run_sum_nxt;
      run_xor_r <= run_xor_nxt;
      hdr_sum_r <= hdr_sum_nxt;
      hdr_xor_r <= hdr_xor_nxt;
      serial_r  <= serial_nxt;
    end
  end

  // check enforcement register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enforce_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enforce_r <= cfg_wr_data;
    end
  end

  // a result only comes from an accepted byte
  a_res_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> acc)
    else $error("result without accepted byte");

  // a buffer end always leaves the parser hunting
  a_chunk_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_item.chunk_end) |=> (phase_r == PH_HUNT))
    else $error("frame still open after buffer end");

  // payload phase always has bytes left to deliver
  a_payload_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (remain_r != '0))
    else $error("payload phase with nothing remaining");

endmodule

>>> rtl/lfd_out_fifo.sv
// lfd_out_fifo: two-entry result queue between the parser and the output port
// depends on lfd_pkg; ready toward the parser comes from a register
module lfd_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  lfd_pkg::res_t     res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output lfd_pkg::out_item_t out_data
);

  lfd_pkg::out_item_t ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push      = res.valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign space     = (count_r != 2'd2);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= res.item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  // no write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && count_r == 2'd2))
    else $error("result queue overflow");

  // pointers differ by the fill count
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/light_frame_deframer.sv
// light_frame_deframer: top level of the byte-stream frame deframer
// depends on lfd_pkg, lfd_parse and lfd_out_fifo
//
//   channel | ports                       | payload
//   --------+-----------------------------+------------------------------
//   input   | in_valid  in_ready  in_data | lfd_pkg::in_item_t, one byte
//   result  | out_valid out_ready out_data| lfd_pkg::out_item_t
//   config  | cfg_wr_en cfg_wr_data       | enforce_checks bit
//
// one byte per cycle while in_ready is high: each transfer updates the frame
// state, and its result, if any, is queued and shows once earlier ones are taken
// a two-entry result queue keeps in_ready up while one result waits
// in_ready drops only when two results wait untaken
// synchronous active-low reset returns to hunting for a head byte, no sweep
module light_frame_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfd_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  lfd_pkg::res_t res;
  logic          acc;

  assign acc = in_valid && in_ready;

  // per-byte parser
  lfd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_item     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  // result queue
  lfd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
